[rtl/pswdt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pswdt_pkg;

   localparam int unsigned SLOT_COUNT_DEF = 8;

   localparam int unsigned ACTION_W   = 1;
   localparam int unsigned SLOT_W     = 8;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned KIND_W     = 2;

   localparam logic [ACTION_W-1:0] ACT_ARM   = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_CHECK = 1'b1;

   localparam logic [KIND_W-1:0] KIND_ARM     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FINISH  = 2'd2;

   // all ones marks a slot (or the summary) as inactive
   localparam logic [TIME_W-1:0] INACTIVE = '1;

   // scan token and running minimum handed from cell to cell
   typedef struct packed {
      logic              tok;
      logic [TIME_W-1:0] least;
   } link_type;

endpackage

`default_nettype wire

[rtl/pswdt_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pswdt_req_if
   import pswdt_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SLOT_W-1:0]   slot;
   logic [TIME_W-1:0]   delay_ms;
   logic [TIME_W-1:0]   now_ms;

   modport source (output valid, action, slot, delay_ms, now_ms, input ready);
   modport sink   (input valid, action, slot, delay_ms, now_ms, output ready);
endinterface

`default_nettype wire

[rtl/pswdt_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pswdt_rsp_if
   import pswdt_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SLOT_W-1:0] fired_slot;
   logic [TIME_W-1:0] next_deadline_ms;
   logic              bad_slot;
   logic              last;

   modport source (output valid, kind, fired_slot, next_deadline_ms, bad_slot, last,
                   input ready);
   modport sink   (input valid, kind, fired_slot, next_deadline_ms, bad_slot, last,
                   output ready);
endinterface

`default_nettype wire

[rtl/pswdt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module pswdt_cell
   import pswdt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [TIME_W-1:0] now,
   input  wire logic              wr_en,
   input  wire logic [TIME_W-1:0] wr_data,
   input  wire link_type          link_in,
   output link_type               link_out,
   output logic                   fire
);

   logic [TIME_W-1:0] deadline_ff, deadline_in;
   logic              tok_ff;
   logic [TIME_W-1:0] least_ff, least_in;

   // token present: expire if active and due, else fold into the minimum
   always_comb begin
      fire        = link_in.tok && (deadline_ff != INACTIVE) && (deadline_ff <= now);
      deadline_in = deadline_ff;
      least_in    = link_in.least;
      if (wr_en) begin
         deadline_in = wr_data;
      end else if (fire && step) begin
         deadline_in = INACTIVE;
      end
      if (!fire && (deadline_ff < link_in.least)) begin
         least_in = deadline_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff <= INACTIVE;
         tok_ff      <= 1'b0;
      end else begin
         deadline_ff <= deadline_in;
         if (step) begin
            tok_ff <= link_in.tok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         least_ff <= least_in;
      end
   end

   assign link_out.tok   = tok_ff;
   assign link_out.least = least_ff;

endmodule

`default_nettype wire

[rtl/per_slot_deadline_watchdog_table.sv]
`timescale 1ns / 1ps
`default_nettype none

// Per-slot deadline watchdog. Each of SLOT_COUNT slots holds an absolute
// 32-bit deadline (all ones = inactive). An arm beat stores now_ms + delay_ms
// (32-bit wrap) in the named slot and lowers the next-deadline summary; it
// answers with one acknowledge beat the cycle after acceptance. An arm naming
// a slot at or beyond SLOT_COUNT changes nothing and is flagged with bad_slot.
// A check beat sends a token down the row of slot cells, one cell per cycle
// while the result side is free; each due slot yields an expiry beat in
// ascending order and goes inactive, and a finish beat then carries the
// least remaining deadline. A check occupies the block until its finish
// beat, since the token walks the cell row one step per free output cycle;
// one item is in work at a time. Reset leaves all slots inactive.

module per_slot_deadline_watchdog_table
   import pswdt_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pswdt_req_if.sink  req,
   pswdt_rsp_if.source rsp
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff, state_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [SLOT_W-1:0] fired_ff, fired_in;
   logic [TIME_W-1:0] next_ff, next_in;
   logic              bad_ff, bad_in;
   logic              last_ff, last_in;

   logic [TIME_W-1:0] earliest_ff, earliest_in;
   logic [TIME_W-1:0] now_ff;
   logic              start_ff, start_in;

   logic              out_free, step, req_beat, arm_beat, check_beat, slot_ok;
   logic [TIME_W-1:0] arm_deadline;
   logic [SLOT_W-1:0] fire_idx;
   logic              fire_any;

   link_type                link [SLOT_COUNT+1];
   logic [SLOT_COUNT-1:0]   fire;
   logic [SLOT_COUNT-1:0]   wr_en;

   // the chain moves only when the output register can take a beat
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign step       = out_free;
   assign req.ready  = (state_ff == ST_IDLE) && out_free;
   assign req_beat   = req.valid && req.ready;
   assign arm_beat   = req_beat && (req.action == ACT_ARM);
   assign check_beat = req_beat && (req.action == ACT_CHECK);
   assign slot_ok    = ({24'd0, req.slot} < 32'(SLOT_COUNT));
   assign arm_deadline = req.now_ms + req.delay_ms;

   // head of the chain: token injected by a check, minimum starts inactive
   assign link[0].tok   = start_ff;
   assign link[0].least = INACTIVE;

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      assign wr_en[i] = arm_beat && slot_ok && (req.slot == SLOT_W'(i));
      pswdt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (step),
         .now      (now_ff),
         .wr_en    (wr_en[i]),
         .wr_data  (arm_deadline),
         .link_in  (link[i]),
         .link_out (link[i+1]),
         .fire     (fire[i])
      );
   end

   // only one cell holds the token, so an OR picks the firing slot
   always_comb begin
      fire_idx = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (fire[i]) fire_idx = fire_idx | SLOT_W'(i);
      end
   end
   assign fire_any = |fire;

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      earliest_in  = earliest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      kind_in      = kind_ff;
      fired_in     = fired_ff;
      next_in      = next_ff;
      bad_in       = bad_ff;
      last_in      = last_ff;

      if (step && start_ff) start_in = 1'b0;

      if (arm_beat) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_ARM;
         fired_in     = '0;
         bad_in       = !slot_ok;
         last_in      = 1'b1;
         next_in      = earliest_ff;
         if (slot_ok && (arm_deadline < earliest_ff)) begin
            earliest_in = arm_deadline;
            next_in     = arm_deadline;
         end
      end else if (check_beat) begin
         state_in = ST_SCAN;
         start_in = 1'b1;
      end else if (step && fire_any) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_EXPIRED;
         fired_in     = fire_idx;
         next_in      = '0;
         bad_in       = 1'b0;
         last_in      = 1'b0;
      end else if (step && link[SLOT_COUNT].tok) begin
         // token left the last cell: scan complete
         rsp_valid_in = 1'b1;
         kind_in      = KIND_FINISH;
         fired_in     = '0;
         next_in      = link[SLOT_COUNT].least;
         bad_in       = 1'b0;
         last_in      = 1'b1;
         earliest_in  = link[SLOT_COUNT].least;
         state_in     = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         earliest_ff  <= INACTIVE;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         earliest_ff  <= earliest_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      fired_ff <= fired_in;
      next_ff  <= next_in;
      bad_ff   <= bad_in;
      last_ff  <= last_in;
      if (check_beat) now_ff <= req.now_ms;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.kind             = kind_ff;
   assign rsp.fired_slot       = fired_ff;
   assign rsp.next_deadline_ms = next_ff;
   assign rsp.bad_slot         = bad_ff;
   assign rsp.last             = last_ff;

endmodule

`default_nettype wire
